// ===== sv/tmhs_pkg.sv =====
// tmhs_pkg: beat types, codes and cell link structs for the time-merging hit store
// used by tmhs_cell and time_merging_hit_store; no dependencies
`default_nettype none

package tmhs_pkg;

	localparam int HIT_TIME_W  = 32;
	localparam int HIT_COUNT_W = 16;
	localparam int ENTRY_CNT_W = 32;
	localparam int THRESH_W    = 9;
	localparam int WINDOW_W    = 16;
	localparam int USED_W      = 9;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(100);
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1000);

	// register word index taken from paddr[2]
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_WINDOW    = 1'b1;

	localparam logic [1:0] MODE_DETECT = 2'd0;
	localparam logic [1:0] MODE_CLEAR  = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic [2:0] ST_APPEND      = 3'd0;
	localparam logic [2:0] ST_INSERT      = 3'd1;
	localparam logic [2:0] ST_MERGE_EARLY = 3'd2;
	localparam logic [2:0] ST_MERGE_LATE  = 3'd3;
	localparam logic [2:0] ST_DROP        = 3'd4;
	localparam logic [2:0] ST_DONE        = 3'd5;

	typedef struct packed {
		logic [1:0]             mode;
		logic [HIT_TIME_W-1:0]  hit_time;
		logic [HIT_COUNT_W-1:0] hit_count;
		logic [7:0]             read_index;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]             status;
		logic [USED_W-1:0]      entries_used;
		logic                   read_valid;
		logic [HIT_TIME_W-1:0]  read_time;
		logic [ENTRY_CNT_W-1:0] read_count;
	} out_beat_t;

	// broadcast to every cell in the compare stage
	typedef struct packed {
		logic                  capture;
		logic [HIT_TIME_W-1:0] hit_time;
		logic [WINDOW_W-1:0]   window;
	} cell_cmp_t;

	// broadcast to every cell in the update stage
	typedef struct packed {
		logic                   en;
		logic                   below;
		logic                   insert_en;
		logic [HIT_TIME_W-1:0]  hit_time;
		logic [HIT_COUNT_W-1:0] hit_count;
	} cell_upd_t;

	// what one cell shows its neighbors and the top level
	typedef struct packed {
		logic                   flag;
		logic                   merge_e;
		logic                   merge_l;
		logic                   pick;
		logic [HIT_TIME_W-1:0]  entry_time;
		logic [ENTRY_CNT_W-1:0] entry_count;
	} cell_link_t;

endpackage

`default_nettype wire

// ===== sv/tmhs_cell.sv =====
// tmhs_cell: one slot of the sorted hit row; compares against the hit, then merges,
// shifts from its left neighbor or loads the hit. depends on tmhs_pkg
`default_nettype none

module tmhs_cell
	import tmhs_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_cmp_t  cmp,
	input  wire cell_upd_t  upd,
	input  wire logic       live,
	input  wire logic       pick,
	input  wire cell_link_t prev,
	input  wire logic       next_flag,
	output cell_link_t      link
);

	logic [HIT_TIME_W-1:0]  time_q;
	logic [ENTRY_CNT_W-1:0] count_q;

	logic lt_s2, le_s2, near_a_s2, near_b_s2, live_s2, pick_s2;

	logic [HIT_TIME_W-1:0]  diff_a, diff_b;
	logic                   flag, merge_e, merge_l;
	logic [ENTRY_CNT_W:0]   sum;
	logic [ENTRY_CNT_W-1:0] sat_count;

	always_comb begin
		diff_a = cmp.hit_time - time_q;
		diff_b = time_q - cmp.hit_time;
	end

	always_ff @(posedge clk) begin
		if (cmp.capture) begin
			lt_s2     <= time_q < cmp.hit_time;
			le_s2     <= time_q <= cmp.hit_time;
			near_a_s2 <= diff_a < HIT_TIME_W'(cmp.window);
			near_b_s2 <= diff_b < HIT_TIME_W'(cmp.window);
			live_s2   <= live;
			pick_s2   <= pick;
		end
	end

	always_comb begin
		// entries before the hit position; below threshold equal times stay ahead
		flag    = live_s2 && (upd.below ? le_s2 : lt_s2);
		merge_e = !upd.below && flag && !next_flag && near_a_s2;
		merge_l = !upd.below && live_s2 && !flag && prev.flag && !prev.merge_e && near_b_s2;
		sum     = {1'b0, count_q} + (ENTRY_CNT_W+1)'(upd.hit_count);
		sat_count = sum[ENTRY_CNT_W] ? '1 : sum[ENTRY_CNT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			if (merge_e) begin
				count_q <= sat_count;
			end else if (merge_l) begin
				count_q <= sat_count;
				time_q  <= upd.hit_time;
			end else if (upd.insert_en && !flag) begin
				if (prev.flag) begin
					time_q  <= upd.hit_time;
					count_q <= ENTRY_CNT_W'(upd.hit_count);
				end else begin
					time_q  <= prev.entry_time;
					count_q <= prev.entry_count;
				end
			end
		end
	end

	always_comb begin
		link.flag        = flag;
		link.merge_e     = merge_e;
		link.merge_l     = merge_l;
		link.pick        = pick_s2;
		link.entry_time  = time_q;
		link.entry_count = count_q;
	end

endmodule

`default_nettype wire

// ===== sv/time_merging_hit_store.sv =====
// time_merging_hit_store: top level, beat stages, apb registers and the row of cells
// depends on tmhs_pkg and tmhs_cell
//
// Keeps up to STORE_DEPTH entries sorted by time in a row of cells, one entry per cell.
// An accepted beat is compared against every cell in the following cycle; then, once
// the output can take the result, each cell merges, shifts one place right or loads
// the hit, while the result goes into the output register. No new beat is taken while
// one is in the compare stage, as the compare stage and update stage both work on the
// same row; a stalled output holds the update stage and with it the input. Stored
// entries have no reset and no clearing pass: only entries below the fill count are
// ever read, and clear just zeroes that count. Configuration registers are threshold
// at 0x0 and merge window at 0x4; write them only while the block is idle.
`default_nettype none

module time_merging_hit_store
	import tmhs_pkg::*;
#(
	parameter int STORE_DEPTH = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_beat_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_beat_t                  out_data,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int CW   = $clog2(STORE_DEPTH + 1);
	localparam int CMPW = (CW > THRESH_W) ? CW : THRESH_W;

	logic [THRESH_W-1:0] thresh_q;
	logic [WINDOW_W-1:0] window_q;
	logic [CW-1:0]       total_q;

	in_beat_t  item_s1, item_s2;
	logic      s1_v_q, s2_v_q, below_s2;
	out_beat_t out_q;
	logic      out_v_q;

	logic accept, s2_go, full, any_me, any_ml, any_pick, insert_en;
	logic [HIT_TIME_W-1:0]  rd_time;
	logic [ENTRY_CNT_W-1:0] rd_count;
	logic [2:0]             status;
	logic [CW-1:0]          total_nx;
	logic [CMPW-1:0]        total_ext;

	logic [STORE_DEPTH-1:0] me_vec, ml_vec;

	cell_cmp_t  cmp;
	cell_upd_t  upd;
	cell_link_t link [STORE_DEPTH];
	cell_link_t head;

	// apb registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_THRESHOLD: thresh_q <= pwdata[THRESH_W-1:0];
				REG_WINDOW:    window_q <= pwdata[WINDOW_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_THRESHOLD: prdata = APB_DATA_W'(thresh_q);
			REG_WINDOW:    prdata = APB_DATA_W'(window_q);
			default:       prdata = '0;
		endcase
	end

	// beat flow: accept -> compare (s1) -> update and result (s2)
	assign s2_go    = s2_v_q && (!out_v_q || out_ready);
	assign in_ready = !s1_v_q && (!s2_v_q || s2_go);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
			total_q <= '0;
		end else begin
			s1_v_q <= accept;
			s2_v_q <= s1_v_q || (s2_v_q && !s2_go);
			if (s2_go) begin
				out_v_q <= 1'b1;
				total_q <= total_nx;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if (s1_v_q) begin
			item_s2  <= item_s1;
			below_s2 <= CMPW'(total_q) < CMPW'(thresh_q);
		end
		if (s2_go) begin
			out_q.status       <= status;
			out_q.entries_used <= total_ext[USED_W-1:0];
			out_q.read_valid   <= any_pick;
			out_q.read_time    <= rd_time;
			out_q.read_count   <= rd_count;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// row of cells
	always_comb begin
		cmp.capture  = s1_v_q;
		cmp.hit_time = item_s1.hit_time;
		cmp.window   = window_q;
	end

	// left edge: the hit may always go in front, never merge later into cell 0
	always_comb begin
		head.flag        = 1'b1;
		head.merge_e     = 1'b1;
		head.merge_l     = 1'b0;
		head.pick        = 1'b0;
		head.entry_time  = '0;
		head.entry_count = '0;
	end

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		logic live, pick;
		assign live = 32'(total_q) > i;
		assign pick = live && (32'(item_s1.read_index) == i);

		tmhs_cell u_cell (
			.clk       (clk),
			.cmp       (cmp),
			.upd       (upd),
			.live      (live),
			.pick      (pick),
			.prev      ((i == 0) ? head : link[(i == 0) ? 0 : i - 1]),
			.next_flag ((i == STORE_DEPTH - 1) ? 1'b0
			            : link[(i == STORE_DEPTH - 1) ? i : i + 1].flag),
			.link      (link[i])
		);

		assign me_vec[i] = link[i].merge_e;
		assign ml_vec[i] = link[i].merge_l;
	end

	always_comb begin
		rd_time  = '0;
		rd_count = '0;
		any_pick = 1'b0;
		if (item_s2.mode == MODE_READ) begin
			for (int k = 0; k < STORE_DEPTH; k++) begin
				if (link[k].pick) begin
					rd_time  = rd_time | link[k].entry_time;
					rd_count = rd_count | link[k].entry_count;
					any_pick = 1'b1;
				end
			end
		end
	end

	always_comb begin
		any_me    = |me_vec;
		any_ml    = |ml_vec;
		full      = total_q == CW'(STORE_DEPTH);
		insert_en = !any_me && !any_ml && !full;

		upd.en        = s2_go && (item_s2.mode == MODE_DETECT);
		upd.below     = below_s2;
		upd.insert_en = insert_en;
		upd.hit_time  = item_s2.hit_time;
		upd.hit_count = item_s2.hit_count;

		total_nx = total_q;
		case (item_s2.mode)
			MODE_DETECT: begin
				if (any_me) begin
					status = ST_MERGE_EARLY;
				end else if (any_ml) begin
					status = ST_MERGE_LATE;
				end else if (full) begin
					status = ST_DROP;
				end else begin
					status   = below_s2 ? ST_APPEND : ST_INSERT;
					total_nx = total_q + CW'(1);
				end
			end
			MODE_CLEAR: begin
				status   = ST_DONE;
				total_nx = '0;
			end
			default: status = ST_DONE;
		endcase
		total_ext = CMPW'(total_nx);
	end

	// checks
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= STORE_DEPTH)
		else $error("fill count beyond store depth");

	a_one_merge_early: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> $onehot0(me_vec))
		else $error("more than one cell merges into earlier entry");

	a_one_merge_late: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> ($onehot0(ml_vec) && !(any_me && any_ml)))
		else $error("conflicting merges in the row");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q |=> (s2_v_q && !s1_v_q))
		else $error("compare stage did not hand over to update stage");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go |=> out_v_q)
		else $error("update stage finished without a result beat");

endmodule

`default_nettype wire

// ===== sim/tmhs_checker.sv =====
// tmhs_checker: watches the hit and result channels and the apb writes, predicts
// every result beat of the time-merging hit store and compares it field by field
// depends on tmhs_pkg
module tmhs_checker
	import tmhs_pkg::*;
#(
	parameter int STORE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_beat_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_beat_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int                    fail_count,
	output int                    pending
);

	logic [HIT_TIME_W-1:0]  shadow_time [STORE_DEPTH];
	logic [ENTRY_CNT_W-1:0] shadow_count [STORE_DEPTH];
	int                     shadow_total;
	logic [THRESH_W-1:0]    threshold;
	logic [WINDOW_W-1:0]    window;
	out_beat_t              result_q [$];

	function automatic logic [ENTRY_CNT_W-1:0] sat_add(logic [ENTRY_CNT_W-1:0] a,
			logic [HIT_COUNT_W-1:0] b);
		logic [ENTRY_CNT_W:0] s;
		s = {1'b0, a} + (ENTRY_CNT_W+1)'(b);
		return s[ENTRY_CNT_W] ? '1 : s[ENTRY_CNT_W-1:0];
	endfunction

	function automatic void place_entry(int pos, logic [HIT_TIME_W-1:0] t,
			logic [HIT_COUNT_W-1:0] c);
		int i;
		for (i = shadow_total; i > pos; i--) begin
			shadow_time[i] = shadow_time[i-1];
			shadow_count[i] = shadow_count[i-1];
		end
		shadow_time[pos] = t;
		shadow_count[pos] = ENTRY_CNT_W'(c);
		shadow_total++;
	endfunction

	// places the hit in time order, merges it into a neighbor, or drops it
	function automatic logic [2:0] store_hit(logic [HIT_TIME_W-1:0] t,
			logic [HIT_COUNT_W-1:0] c);
		int p;
		logic [HIT_TIME_W-1:0] gap_prev, gap_next;
		p = 0;
		if (shadow_total < int'(threshold)) begin
			if (shadow_total >= STORE_DEPTH)
				return ST_DROP;
			// equal times keep arrival order
			while (p < shadow_total && shadow_time[p] <= t)
				p++;
			place_entry(p, t, c);
			return ST_APPEND;
		end
		while (p < shadow_total && shadow_time[p] < t)
			p++;
		if (p > 0) begin
			gap_prev = t - shadow_time[p-1];
			if (gap_prev < HIT_TIME_W'(window)) begin
				shadow_count[p-1] = sat_add(shadow_count[p-1], c);
				return ST_MERGE_EARLY;
			end
			if (p < shadow_total) begin
				gap_next = shadow_time[p] - t;
				if (gap_next < HIT_TIME_W'(window)) begin
					shadow_count[p] = sat_add(shadow_count[p], c);
					shadow_time[p] = t;
					return ST_MERGE_LATE;
				end
			end
		end
		if (shadow_total >= STORE_DEPTH)
			return ST_DROP;
		place_entry(p, t, c);
		return ST_INSERT;
	endfunction

	function automatic out_beat_t predict_result(in_beat_t b);
		out_beat_t r;
		r = '0;
		r.status = ST_DONE;
		case (b.mode)
			MODE_DETECT: begin
				r.status = store_hit(b.hit_time, b.hit_count);
			end
			MODE_CLEAR: begin
				shadow_total = 0;
			end
			MODE_READ: begin
				if (int'(b.read_index) < shadow_total) begin
					r.read_valid = 1'b1;
					r.read_time = shadow_time[b.read_index];
					r.read_count = shadow_count[b.read_index];
				end
			end
			default: ;
		endcase
		r.entries_used = USED_W'(shadow_total);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			shadow_total = 0;
			threshold = THRESH_RESET;
			window = WINDOW_RESET;
			result_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_THRESHOLD)
					threshold = pwdata[THRESH_W-1:0];
				else
					window = pwdata[WINDOW_W-1:0];
			end
			if (in_valid && in_ready)
				result_q.insert(result_q.size(), predict_result(in_data));
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat: status %0d used %0d",
							out_data.status, out_data.entries_used);
					fail_count <= fail_count + 1;
				end else begin
					want = result_q.pop_front();
					if (want.status !== out_data.status
							|| want.entries_used !== out_data.entries_used
							|| want.read_valid !== out_data.read_valid
							|| want.read_time !== out_data.read_time
							|| want.read_count !== out_data.read_count) begin
						if (fail_count < 10) begin
							$display("mismatch exp: status %0d used %0d valid %b time %h count %h",
								want.status, want.entries_used, want.read_valid,
								want.read_time, want.read_count);
							$display("         got: status %0d used %0d valid %b time %h count %h",
								out_data.status, out_data.entries_used, out_data.read_valid,
								out_data.read_time, out_data.read_count);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= result_q.size();
		end
	end

endmodule

// ===== sim/tb_time_merging_hit_store.sv =====
// tb_time_merging_hit_store: drives hits, clears and reads into the hit store under
// several register settings and gives the verdict; depends on tmhs_pkg,
// time_merging_hit_store and tmhs_checker
module tb_time_merging_hit_store;
	import tmhs_pkg::*;

	localparam int DEPTH = 256;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_beat_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_beat_t             out_data;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    fail_count;
	int                    pending;
	bit                    fast = 1'b0;
	int                    ready_hold = 0;
	int                    pick;

	time_merging_hit_store #(.STORE_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tmhs_checker #(.STORE_DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	always #2 clk = ~clk;

	// result side: ready runs, short stalls, now and then a long one
	always @(posedge clk) begin
		if (fast) begin
			out_ready <= 1'b1;
			ready_hold <= 0;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				out_ready <= 1'b1;
				ready_hold <= $urandom_range(1, 40);
			end else if (pick < 90) begin
				out_ready <= 1'b0;
				ready_hold <= $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b0;
				ready_hold <= $urandom_range(10, 40);
			end
		end
	end

	task automatic send_beat(input logic [1:0] m, input logic [HIT_TIME_W-1:0] t,
			input logic [HIT_COUNT_W-1:0] c, input logic [7:0] idx);
		in_beat_t b;
		int gap, r;
		b.mode = m;
		b.hit_time = t;
		b.hit_count = c;
		b.read_index = idx;
		r = $urandom_range(0, 99);
		gap = fast ? 0 : (r < 70) ? 0 : (r < 92) ? $urandom_range(1, 3)
			: $urandom_range(10, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// sender holds off until every predicted result has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_write(input logic sel, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input int thr, input int win);
		wait_drained();
		apb_write(REG_THRESHOLD, APB_DATA_W'(thr));
		apb_write(REG_WINDOW, APB_DATA_W'(win));
	endtask

	initial begin
		int thr, win, span, r, k;
		logic [HIT_TIME_W-1:0] base;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: order below threshold, every merge path, window edges, extremes
		set_config(3, 1000);
		send_beat(MODE_READ, '0, '0, 8'd0);
		send_beat(MODE_CLEAR, '0, '0, '0);
		send_beat(MODE_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		send_beat(MODE_DETECT, 32'd5000, 16'd10, '0);
		send_beat(MODE_DETECT, 32'd5000, 16'hFFFF, '0);
		send_beat(MODE_DETECT, 32'd3000, 16'd1, '0);
		send_beat(MODE_READ, '0, '0, 8'd0);
		send_beat(MODE_READ, '0, '0, 8'd1);
		send_beat(MODE_READ, '0, '0, 8'd2);
		send_beat(MODE_DETECT, 32'd100, 16'd1, '0);
		send_beat(MODE_DETECT, 32'd5500, 16'd2, '0);
		send_beat(MODE_DETECT, 32'd4500, 16'd3, '0);
		send_beat(MODE_DETECT, 32'd3999, 16'd4, '0);
		send_beat(MODE_DETECT, 32'd4000, 16'd5, '0);
		send_beat(MODE_DETECT, 32'd2000, 16'd6, '0);
		send_beat(MODE_DETECT, 32'hFFFF_FFFF, 16'hFFFF, '0);
		send_beat(MODE_DETECT, 32'd0, 16'd0, '0);
		send_beat(MODE_DETECT, 32'd0, 16'd5, '0);
		send_beat(MODE_READ, '0, '0, 8'd255);
		send_beat(MODE_READ, '0, '0, 8'd1);
		send_beat(MODE_READ, '0, '0, 8'd3);
		send_beat(MODE_CLEAR, '0, '0, '0);
		send_beat(MODE_READ, '0, '0, 8'd0);

		// repeated merges into one entry, back to back
		set_config(0, 65535);
		fast = 1'b1;
		send_beat(MODE_CLEAR, '0, '0, '0);
		send_beat(MODE_DETECT, 32'd1000, 16'hFFFF, '0);
		repeat (16) send_beat(MODE_DETECT, 32'd1001, 16'hFFFF, '0);
		send_beat(MODE_READ, '0, '0, 8'd0);
		fast = 1'b0;

		// full store: fill to the last cell, then drops and merges while full
		set_config(DEPTH, 0);
		send_beat(MODE_CLEAR, '0, '0, '0);
		for (k = 0; k < DEPTH; k++)
			send_beat(MODE_DETECT, k * 100000 + $urandom_range(0, 1000),
				16'($urandom), '0);
		repeat (8) send_beat(MODE_DETECT, $urandom, 16'($urandom), '0);
		send_beat(MODE_READ, '0, '0, 8'd255);
		send_beat(MODE_READ, '0, '0, 8'd0);
		set_config(DEPTH, 20000);
		repeat (60) begin
			k = $urandom_range(1, DEPTH - 1);
			r = $urandom_range(0, 2);
			if (r == 0)
				send_beat(MODE_DETECT, k * 100000 + 1500, 16'($urandom), '0);
			else if (r == 1)
				send_beat(MODE_DETECT, k * 100000 - 1000, 16'($urandom), '0);
			else
				send_beat(MODE_DETECT, k * 100000 + 50000, 16'($urandom), '0);
		end
		repeat (20) send_beat(MODE_READ, '0, '0, 8'($urandom));

		// random phases under changing settings
		repeat (8) begin
			r = $urandom_range(0, 4);
			thr = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? $urandom_range(2, 20)
				: (r == 3) ? 100 : $urandom_range(0, DEPTH);
			r = $urandom_range(0, 3);
			win = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? $urandom_range(2, 5000)
				: 65535;
			set_config(thr, win);
			if ($urandom_range(0, 1))
				send_beat(MODE_CLEAR, '0, '0, '0);
			base = $urandom;
			span = win * 4 + 10;
			repeat (75) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					send_beat(MODE_DETECT, base + $urandom_range(0, span),
						16'($urandom), '0);
				else if (r < 73)
					send_beat(MODE_DETECT, $urandom_range(0, 1) ? '1 : '0,
						16'($urandom), '0);
				else if (r < 77)
					send_beat(MODE_DETECT, $urandom, 16'($urandom), '0);
				else if (r < 92)
					send_beat(MODE_READ, $urandom, 16'($urandom),
						$urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom));
				else if (r < 95)
					send_beat(MODE_CLEAR, $urandom, 16'($urandom), 8'($urandom));
				else
					send_beat(MODE_SPARE, $urandom, 16'($urandom), 8'($urandom));
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS time_merging_hit_store");
		else
			$display("FAIL time_merging_hit_store");
		$finish;
	end

	initial begin
		#8000000;
		$display("FAIL time_merging_hit_store");
		$finish;
	end

endmodule
